// ===== rtl/plg_pkg.sv =====
`timescale 1ns / 1ps

package plg_pkg;

    localparam int MAX_POINTS_DEF     = 1024;
    localparam int WINDOW_DIVISOR_DEF = 10;

    localparam logic [15:0] LOOKAHEAD_RST = 16'd500;

    localparam int IDX_OUT_W = 10;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] heading;
    } point_t;

    localparam int POINT_W = $bits(point_t);

endpackage

// ===== rtl/pursuit_lookahead_goal_search.sv =====
`timescale 1ns / 1ps

// Append, clear and ignored modes give no word.
// Dropped append or query on an empty table goes straight from idle to done and loads its word.
// Query: set-up states, window reads from the last closest point, a drain, then goal reads past the
// new closest point until a goal or the table end, a drain, done; no goal reads if closest is last.
// Next word is taken the cycle after the result loads; a stalled result holds the input.
// Sync active-low reset empties the table, zeroes the closest index, lookahead 500; RAM kept.
module pursuit_lookahead_goal_search #(
    parameter int MAX_POINTS     = plg_pkg::MAX_POINTS_DEF,
    parameter int WINDOW_DIVISOR = plg_pkg::WINDOW_DIVISOR_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_lookahead_dist,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [15:0] s_wp_x,
    input  logic signed [15:0] s_wp_y,
    input  logic signed [15:0] s_wp_heading,
    input  logic signed [15:0] s_robot_x,
    input  logic signed [15:0] s_robot_y,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic signed [15:0] m_goal_x,
    output logic signed [15:0] m_goal_y,
    output logic signed [15:0] m_goal_heading,
    output logic [9:0]         m_closest_index,
    output logic               m_table_full
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int RW = $clog2(WINDOW_DIVISOR + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SET1   = 4'd1;
    localparam logic [3:0] ST_SET2   = 4'd2;
    localparam logic [3:0] ST_WIN    = 4'd3;
    localparam logic [3:0] ST_WDRAIN = 4'd4;
    localparam logic [3:0] ST_SETG   = 4'd5;
    localparam logic [3:0] ST_GOAL   = 4'd6;
    localparam logic [3:0] ST_GDRAIN = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]            state_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         span_reg;
    logic [RW-1:0]         rem_reg;
    logic [AW-1:0]         lc_reg;
    logic [15:0]           lookahead_reg;
    logic [31:0]           la2_reg;

    logic signed [15:0]    ref_x_reg;
    logic signed [15:0]    ref_y_reg;
    logic [AW-1:0]         start_reg;
    logic [CW-1:0]         end_reg;
    logic [CW-1:0]         addr_reg;
    logic                  goal_ph_reg;

    logic [32:0]           best_d_reg;
    logic [AW-1:0]         best_idx_reg;
    logic [15:0]           best_x_reg;
    logic [15:0]           best_y_reg;

    logic                  hit_reg;
    plg_pkg::point_t       goal_reg;
    logic [AW-1:0]         res_idx_reg;
    logic                  res_full_reg;

    logic                  rd_vld_reg;
    logic [AW-1:0]         rd_tag_reg;

    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic [15:0]           m_goal_x_reg;
    logic [15:0]           m_goal_y_reg;
    logic [15:0]           m_goal_heading_reg;
    logic [9:0]            m_closest_reg;
    logic                  m_full_reg;

    logic                  s_fire;
    logic                  table_is_full;
    logic                  ram_we;
    plg_pkg::point_t       wr_point;
    plg_pkg::point_t       rd_point;
    logic                  issue;
    logic [CW-1:0]         addr_inc;
    logic [CW-1:0]         win_sum;
    logic [CW-1:0]         win_end;
    logic [CW-1:0]         lc_ext;
    logic [CW-1:0]         count_m1;
    logic [CW-1:0]         best_nxt;
    logic                  d_valid;
    logic [AW-1:0]         d_tag;
    plg_pkg::point_t       d_point;
    logic [32:0]           d_dist;
    logic                  d_busy;
    logic                  hit_now;
    logic                  pipe_empty;
    logic                  load_out;
    logic [AW+plg_pkg::IDX_OUT_W-1:0] idx_wide;

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign cfg_ready     = 1'b1;
    assign table_is_full = (count_reg == CW'(MAX_POINTS));
    assign ram_we        = s_fire && (s_mode == plg_pkg::MODE_APPEND) && !table_is_full;

    assign wr_point.x       = s_wp_x;
    assign wr_point.y       = s_wp_y;
    assign wr_point.heading = s_wp_heading;

    assign addr_inc = addr_reg + 1'b1;
    assign lc_ext   = {1'b0, lc_reg};
    assign count_m1 = count_reg - 1'b1;
    assign win_sum  = {1'b0, start_reg} + span_reg;
    assign best_nxt = {1'b0, best_idx_reg} + 1'b1;

    always_comb begin
        if (span_reg == '0) begin
            // empty window repaired to its start point
            win_end = {1'b0, start_reg} + 1'b1;
        end else if (win_sum > count_reg) begin
            win_end = count_reg;
        end else begin
            win_end = win_sum;
        end
    end

    assign hit_now = d_valid && goal_ph_reg && !hit_reg && (d_dist >= {1'b0, la2_reg});
    assign issue   = (state_reg == ST_WIN) ||
                     ((state_reg == ST_GOAL) && !hit_now && !hit_reg);
    assign pipe_empty = !rd_vld_reg && !d_busy && !d_valid;
    assign load_out   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign idx_wide   = {{plg_pkg::IDX_OUT_W{1'b0}}, res_idx_reg};

    plg_ram #(
        .WIDTH (plg_pkg::POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_point),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rd_point)
    );

    plg_dist #(
        .TAG_W (AW)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_vld_reg),
        .in_tag    (rd_tag_reg),
        .in_point  (rd_point),
        .ref_x     (ref_x_reg),
        .ref_y     (ref_y_reg),
        .out_valid (d_valid),
        .out_tag   (d_tag),
        .out_point (d_point),
        .out_dist  (d_dist),
        .busy      (d_busy)
    );

    always_ff @(posedge aclk) begin
        la2_reg    <= {16'd0, lookahead_reg} * {16'd0, lookahead_reg};
        rd_tag_reg <= addr_reg[AW-1:0];

        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            span_reg      <= '0;
            rem_reg       <= '0;
            lc_reg        <= '0;
            lookahead_reg <= plg_pkg::LOOKAHEAD_RST;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= issue;

            if (cfg_valid && cfg_ready) begin
                lookahead_reg <= cfg_lookahead_dist;
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // window compare; first read always wins since best_d starts at max
            if (d_valid && !goal_ph_reg && (d_dist < best_d_reg)) begin
                best_d_reg   <= d_dist;
                best_idx_reg <= d_tag;
                best_x_reg   <= d_point.x;
                best_y_reg   <= d_point.y;
            end

            if (hit_now) begin
                hit_reg  <= 1'b1;
                goal_reg <= d_point;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        hit_reg      <= 1'b0;
                        res_full_reg <= 1'b0;
                        unique case (s_mode)
                            plg_pkg::MODE_APPEND: begin
                                if (table_is_full) begin
                                    res_idx_reg  <= lc_reg;
                                    res_full_reg <= 1'b1;
                                    state_reg    <= ST_DONE;
                                end else begin
                                    count_reg <= count_reg + 1'b1;
                                    // running count / WINDOW_DIVISOR
                                    if (rem_reg == RW'(WINDOW_DIVISOR - 1)) begin
                                        rem_reg  <= '0;
                                        span_reg <= span_reg + 1'b1;
                                    end else begin
                                        rem_reg <= rem_reg + 1'b1;
                                    end
                                end
                            end
                            plg_pkg::MODE_QUERY: begin
                                ref_x_reg <= s_robot_x;
                                ref_y_reg <= s_robot_y;
                                if (count_reg == '0) begin
                                    res_idx_reg <= '0;
                                    state_reg   <= ST_DONE;
                                end else begin
                                    state_reg <= ST_SET1;
                                end
                            end
                            plg_pkg::MODE_CLEAR: begin
                                count_reg <= '0;
                                span_reg  <= '0;
                                rem_reg   <= '0;
                                lc_reg    <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SET1: begin
                    if (lc_ext >= count_reg) begin
                        start_reg <= count_m1[AW-1:0];
                    end else begin
                        start_reg <= lc_reg;
                    end
                    state_reg <= ST_SET2;
                end
                ST_SET2: begin
                    end_reg     <= win_end;
                    addr_reg    <= {1'b0, start_reg};
                    best_d_reg  <= '1;
                    goal_ph_reg <= 1'b0;
                    state_reg   <= ST_WIN;
                end
                ST_WIN: begin
                    addr_reg <= addr_inc;
                    if (addr_inc == end_reg) begin
                        state_reg <= ST_WDRAIN;
                    end
                end
                ST_WDRAIN: begin
                    if (pipe_empty) begin
                        state_reg <= ST_SETG;
                    end
                end
                ST_SETG: begin
                    lc_reg      <= best_idx_reg;
                    res_idx_reg <= best_idx_reg;
                    ref_x_reg   <= best_x_reg;
                    ref_y_reg   <= best_y_reg;
                    goal_ph_reg <= 1'b1;
                    addr_reg    <= best_nxt;
                    if (best_nxt >= count_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_GOAL;
                    end
                end
                ST_GOAL: begin
                    if (hit_now || hit_reg) begin
                        state_reg <= ST_GDRAIN;
                    end else begin
                        addr_reg <= addr_inc;
                        if (addr_inc == count_reg) begin
                            state_reg <= ST_GDRAIN;
                        end
                    end
                end
                ST_GDRAIN: begin
                    if (pipe_empty) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end

        if (load_out) begin
            m_found_reg        <= hit_reg;
            m_goal_x_reg       <= hit_reg ? goal_reg.x : 16'd0;
            m_goal_y_reg       <= hit_reg ? goal_reg.y : 16'd0;
            m_goal_heading_reg <= hit_reg ? goal_reg.heading : 16'd0;
            m_closest_reg      <= idx_wide[plg_pkg::IDX_OUT_W-1:0];
            m_full_reg         <= res_full_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_goal_x        = m_goal_x_reg;
    assign m_goal_y        = m_goal_y_reg;
    assign m_goal_heading  = m_goal_heading_reg;
    assign m_closest_index = m_closest_reg;
    assign m_table_full    = m_full_reg;

endmodule

// ===== rtl/plg_ram.sv =====
`timescale 1ns / 1ps

module plg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/plg_dist.sv =====
`timescale 1ns / 1ps

// Two-stage squared distance: subtract and square, then sum.
module plg_dist #(
    parameter int TAG_W = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [TAG_W-1:0]     in_tag,
    input  plg_pkg::point_t      in_point,
    input  logic signed [15:0]   ref_x,
    input  logic signed [15:0]   ref_y,
    output logic                 out_valid,
    output logic [TAG_W-1:0]     out_tag,
    output plg_pkg::point_t      out_point,
    output logic [32:0]          out_dist,
    output logic                 busy
);

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] px;
    logic signed [33:0] py;

    logic                v1_reg;
    logic [TAG_W-1:0]    tag1_reg;
    plg_pkg::point_t     pt1_reg;
    logic [31:0]         sqx_reg;
    logic [31:0]         sqy_reg;

    logic                v2_reg;
    logic [TAG_W-1:0]    tag2_reg;
    plg_pkg::point_t     pt2_reg;
    logic [32:0]         dist_reg;

    assign dx = $signed({in_point.x[15], in_point.x}) - $signed({ref_x[15], ref_x});
    assign dy = $signed({in_point.y[15], in_point.y}) - $signed({ref_y[15], ref_y});
    assign px = 34'(dx) * 34'(dx);
    assign py = 34'(dy) * 34'(dy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        tag1_reg <= in_tag;
        pt1_reg  <= in_point;
        // a 17-bit square never exceeds 32 bits
        sqx_reg  <= px[31:0];
        sqy_reg  <= py[31:0];
        tag2_reg <= tag1_reg;
        pt2_reg  <= pt1_reg;
        dist_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    assign out_valid = v2_reg;
    assign out_tag   = tag2_reg;
    assign out_point = pt2_reg;
    assign out_dist  = dist_reg;
    assign busy      = v1_reg | v2_reg;

endmodule

// ===== rtl/plg_chk.sv =====
`timescale 1ns / 1ps

module plg_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [15:0]        cfg_lookahead_dist,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_mode,
    input logic signed [15:0] s_wp_x,
    input logic signed [15:0] s_wp_y,
    input logic signed [15:0] s_wp_heading,
    input logic signed [15:0] s_robot_x,
    input logic signed [15:0] s_robot_y,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_found,
    input logic signed [15:0] m_goal_x,
    input logic signed [15:0] m_goal_y,
    input logic signed [15:0] m_goal_heading,
    input logic [9:0]         m_closest_index,
    input logic               m_table_full
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_goal_x)
            && $stable(m_goal_y) && $stable(m_goal_heading)
            && $stable(m_closest_index) && $stable(m_table_full))
        else $error("result word changed while stalled");

    a_found_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_table_full)
        else $error("goal reported on a dropped append");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_goal_x == 16'sd0 && m_goal_y == 16'sd0
            && m_goal_heading == 16'sd0)
        else $error("goal fields not zero without a goal");

    // a query always occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == plg_pkg::MODE_QUERY |=> !s_ready)
        else $error("input taken right after a query");

endmodule

bind pursuit_lookahead_goal_search plg_chk u_plg_chk (.*);

// ===== test/pursuit_lookahead_goal_search_tb.sv =====
`timescale 1ns / 1ps

module pursuit_lookahead_goal_search_tb;
    import plg_pkg::*;

    localparam int MAXP = MAX_POINTS_DEF;
    localparam int WIN_DIV = WINDOW_DIVISOR_DEF;
    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES = 2500;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] wp_x;
        logic signed [15:0] wp_y;
        logic signed [15:0] wp_heading;
        logic signed [15:0] robot_x;
        logic signed [15:0] robot_y;
    } traj_word_t;

    typedef struct {
        logic               found;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [15:0] goal_heading;
        logic [9:0]         closest_index;
        logic               table_full;
    } goal_word_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_lookahead_dist = 16'd0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode = 2'd0;
    logic signed [15:0] s_wp_x = '0;
    logic signed [15:0] s_wp_y = '0;
    logic signed [15:0] s_wp_heading = '0;
    logic signed [15:0] s_robot_x = '0;
    logic signed [15:0] s_robot_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic signed [15:0] m_goal_x;
    logic signed [15:0] m_goal_y;
    logic signed [15:0] m_goal_heading;
    logic [9:0]         m_closest_index;
    logic               m_table_full;

    pursuit_lookahead_goal_search dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_lookahead_dist (cfg_lookahead_dist),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_wp_x             (s_wp_x),
        .s_wp_y             (s_wp_y),
        .s_wp_heading       (s_wp_heading),
        .s_robot_x          (s_robot_x),
        .s_robot_y          (s_robot_y),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_found            (m_found),
        .m_goal_x           (m_goal_x),
        .m_goal_y           (m_goal_y),
        .m_goal_heading     (m_goal_heading),
        .m_closest_index    (m_closest_index),
        .m_table_full       (m_table_full)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------- goal search predictor ----------------
    logic signed [15:0] way_x [MAXP];
    logic signed [15:0] way_y [MAXP];
    logic signed [15:0] way_h [MAXP];
    int unsigned        way_count = 0;
    int unsigned        near_idx = 0;
    logic [15:0]        look_dist = LOOKAHEAD_RST;
    goal_word_t         expected_goals[$];

    function automatic longint sq_gap(logic signed [15:0] ax, logic signed [15:0] ay,
                                      logic signed [15:0] bx, logic signed [15:0] by);
        longint dx;
        longint dy;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        return dx * dx + dy * dy;
    endfunction

    task automatic track_word(input traj_word_t w);
        goal_word_t  r;
        int unsigned first;
        int unsigned stop;
        int unsigned best;
        int unsigned i;
        longint      best_d;
        longint      d;
        longint      reach2;
        logic        hit;
        r.found = 1'b0;
        r.goal_x = '0;
        r.goal_y = '0;
        r.goal_heading = '0;
        r.closest_index = '0;
        r.table_full = 1'b0;
        case (w.mode)
            MODE_APPEND: begin
                if (way_count >= MAXP) begin
                    r.table_full = 1'b1;
                    r.closest_index = 10'(near_idx);
                    expected_goals.push_back(r);
                end else begin
                    way_x[way_count] = w.wp_x;
                    way_y[way_count] = w.wp_y;
                    way_h[way_count] = w.wp_heading;
                    way_count++;
                end
            end
            MODE_CLEAR: begin
                way_count = 0;
                near_idx = 0;
            end
            MODE_QUERY: begin
                if (way_count != 0) begin
                    first = near_idx;
                    if (first >= way_count)
                        first = way_count - 1;
                    stop = first + way_count / WIN_DIV;
                    if (stop > way_count)
                        stop = way_count;
                    if (stop <= first)
                        stop = first + 1;
                    best = first;
                    best_d = sq_gap(w.robot_x, w.robot_y, way_x[first], way_y[first]);
                    for (i = first + 1; i < stop; i++) begin
                        d = sq_gap(w.robot_x, w.robot_y, way_x[i], way_y[i]);
                        if (d < best_d) begin
                            best_d = d;
                            best = i;
                        end
                    end
                    near_idx = best;
                    r.closest_index = 10'(best);
                    reach2 = longint'(look_dist) * longint'(look_dist);
                    hit = 1'b0;
                    for (i = best + 1; i < way_count && !hit; i++) begin
                        d = sq_gap(way_x[best], way_y[best], way_x[i], way_y[i]);
                        if (d >= reach2) begin
                            hit = 1'b1;
                            r.found = 1'b1;
                            r.goal_x = way_x[i];
                            r.goal_y = way_y[i];
                            r.goal_heading = way_h[i];
                        end
                    end
                end
                expected_goals.push_back(r);
            end
            default: ;
        endcase
    endtask

    // ---------------- result checking ----------------
    int         mismatches = 0;
    goal_word_t got_goal;
    goal_word_t want_goal;
    traj_word_t taken_word;

    task automatic report_miss(input string why, input goal_word_t want, input goal_word_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected found=%0b x=%0d y=%0d hdg=%0d idx=%0d full=%0b",
                     $realtime, why, want.found, want.goal_x, want.goal_y,
                     want.goal_heading, want.closest_index, want.table_full,
                     "\n    got found=%0b x=%0d y=%0d hdg=%0d idx=%0d full=%0b",
                     got.found, got.goal_x, got.goal_y, got.goal_heading,
                     got.closest_index, got.table_full);
    endtask

    int unsigned in_accepts = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            // check the output first so a word accepted on this edge cannot mask it
            if (m_valid && m_ready) begin
                got_goal.found = m_found;
                got_goal.goal_x = m_goal_x;
                got_goal.goal_y = m_goal_y;
                got_goal.goal_heading = m_goal_heading;
                got_goal.closest_index = m_closest_index;
                got_goal.table_full = m_table_full;
                if (expected_goals.size() == 0) begin
                    report_miss("unexpected word", got_goal, got_goal);
                end else begin
                    want_goal = expected_goals.pop_front();
                    if (got_goal.found !== want_goal.found ||
                        got_goal.goal_x !== want_goal.goal_x ||
                        got_goal.goal_y !== want_goal.goal_y ||
                        got_goal.goal_heading !== want_goal.goal_heading ||
                        got_goal.closest_index !== want_goal.closest_index ||
                        got_goal.table_full !== want_goal.table_full)
                        report_miss("mismatch", want_goal, got_goal);
                end
            end
            if (s_valid && s_ready) begin
                taken_word.mode = s_mode;
                taken_word.wp_x = s_wp_x;
                taken_word.wp_y = s_wp_y;
                taken_word.wp_heading = s_wp_heading;
                taken_word.robot_x = s_robot_x;
                taken_word.robot_y = s_robot_y;
                in_accepts++;
                track_word(taken_word);
            end
        end
    end

    int unsigned cycle_cnt = 0;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("pursuit_lookahead_goal_search_tb: FAIL");
            $finish;
        end
    end

    // ---------------- sender ----------------
    traj_word_t  pending_words[$];
    traj_word_t  next_word;
    int unsigned in_offers = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_accepts == in_offers) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                next_word = pending_words.pop_front();
                s_mode <= next_word.mode;
                s_wp_x <= next_word.wp_x;
                s_wp_y <= next_word.wp_y;
                s_wp_heading <= next_word.wp_heading;
                s_robot_x <= next_word.robot_x;
                s_robot_y <= next_word.robot_y;
                s_valid <= 1'b1;
                in_offers++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------
    logic hold_arm = 1'b0;
    logic hold_active = 1'b0;
    int   rx_left = 0;
    int   rx_style = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 2);
            rx_left = $urandom_range(10, 150);
        end else begin
            rx_left--;
        end
        if (hold_active)
            m_ready <= 1'b0;
        else
            case (rx_style)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
    end

    // long back-pressure stretch: the block must stall its input meanwhile
    initial begin
        wait (hold_arm);
        repeat ($urandom_range(20, 100)) @(negedge aclk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_active <= 1'b0;
    end

    // ---------------- stimulus ----------------
    int                 gen_count = 0;
    int                 gen_items = 0;
    logic signed [15:0] path_x[$];
    logic signed [15:0] path_y[$];

    function automatic logic signed [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic queue_word(input logic [1:0] mode, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [15:0] h,
                              input logic signed [15:0] rx, input logic signed [15:0] ry);
        traj_word_t w;
        w.mode = mode;
        w.wp_x = x;
        w.wp_y = y;
        w.wp_heading = h;
        w.robot_x = rx;
        w.robot_y = ry;
        pending_words.push_back(w);
        if (mode != MODE_IGNORED)
            gen_items++;
        if (mode == MODE_APPEND && gen_count < MAXP) begin
            gen_count++;
            path_x.push_back(x);
            path_y.push_back(y);
        end else if (mode == MODE_CLEAR) begin
            gen_count = 0;
            path_x.delete();
            path_y.delete();
        end
    endtask

    // random walk; a zero step now and then makes duplicate points (closest ties)
    task automatic lay_path(input int n, input int reach);
        int cx;
        int cy;
        if (path_x.size() != 0) begin
            cx = path_x[$];
            cy = path_y[$];
        end else begin
            cx = int'($urandom_range(0, 40000)) - 20000;
            cy = int'($urandom_range(0, 40000)) - 20000;
        end
        repeat (n) begin
            if ($urandom_range(0, 9) != 0) begin
                cx = int'(clamp16(cx + int'($urandom_range(0, 2 * reach)) - reach));
                cy = int'(clamp16(cy + int'($urandom_range(0, 2 * reach)) - reach));
            end
            queue_word(MODE_APPEND, 16'(cx), 16'(cy), rnd16(), rnd16(), rnd16());
        end
    endtask

    // robot creeps along the path with some noise, sometimes jumps anywhere
    task automatic run_queries(input int k);
        int walk;
        int pick;
        walk = 0;
        repeat (k) begin
            if (path_x.size() == 0 || $urandom_range(0, 7) == 0) begin
                queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
            end else begin
                pick = walk + $urandom_range(0, 3);
                if (pick > path_x.size() - 1)
                    pick = path_x.size() - 1;
                walk = pick;
                queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(),
                           clamp16(int'(path_x[pick]) + int'($urandom_range(0, 800)) - 400),
                           clamp16(int'(path_y[pick]) + int'($urandom_range(0, 800)) - 400));
            end
        end
    endtask

    task automatic random_phase(input int budget);
        int stop_at;
        int reach;
        stop_at = gen_items + budget;
        while (gen_items < stop_at) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 6))
                    queue_word(2'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16(),
                               rnd16(), rnd16());
            end else begin
                case ($urandom_range(0, 5))
                    0: reach = 30000;
                    1: reach = 8000;
                    default: reach = 800;
                endcase
                if (gen_count > 300 || $urandom_range(0, 4) != 0)
                    queue_word(MODE_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
                lay_path(($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                      : $urandom_range(1, 40), reach);
                run_queries($urandom_range(1, 12));
                if ($urandom_range(0, 2) == 0) begin
                    lay_path($urandom_range(1, 10), reach);
                    run_queries($urandom_range(1, 5));
                end
            end
        end
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || s_valid || expected_goals.size() != 0)
            @(posedge aclk);
        // trailing append/clear words give no result word, so wait them out
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_lookahead(input logic [15:0] v);
        @(negedge aclk);
        cfg_lookahead_dist <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        look_dist = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, with the lookahead still at its reset value
        queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), 16'sh8000, 16'sh7fff);
        queue_word(MODE_APPEND, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        queue_word(MODE_APPEND, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        queue_word(MODE_APPEND, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), 16'sh8000, 16'sh8000);
        queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), 16'sh7fff, 16'sh7fff);
        queue_word(MODE_IGNORED, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        queue_word(MODE_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), 16'sd0, 16'sd0);
        // points packed inside the lookahead: no goal
        queue_word(MODE_APPEND, 16'sd0, 16'sd0, 16'sd11, rnd16(), rnd16());
        queue_word(MODE_APPEND, 16'sd100, 16'sd0, 16'sd22, rnd16(), rnd16());
        queue_word(MODE_APPEND, 16'sd200, 16'sd0, 16'sd33, rnd16(), rnd16());
        queue_word(MODE_APPEND, 16'sd300, 16'sd0, 16'sd44, rnd16(), rnd16());
        queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), 16'sd0, 16'sd0);
        // exactly on the lookahead counts as reached
        queue_word(MODE_APPEND, 16'sd500, 16'sd0, -16'sd55, rnd16(), rnd16());
        queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), 16'sd0, 16'sd0);
        queue_word(MODE_APPEND, 16'sh8000, 16'sh7fff, 16'sh7fff, rnd16(), rnd16());
        queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(), 16'sd10, -16'sd10);
        queue_word(MODE_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        settle();

        // full table: dropped appends, then queries over the whole store
        set_lookahead(16'd1500);
        lay_path(MAXP, 800);
        queue_word(MODE_APPEND, 16'sh7fff, 16'sh8000, 16'sh7fff, rnd16(), rnd16());
        queue_word(MODE_APPEND, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        run_queries(3);
        queue_word(MODE_APPEND, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        queue_word(MODE_QUERY, rnd16(), rnd16(), rnd16(),
                   path_x[MAXP - 1], path_y[MAXP - 1]);
        queue_word(MODE_APPEND, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        queue_word(MODE_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        settle();

        set_lookahead(16'd0);
        random_phase(100);
        hold_arm = 1'b1;
        settle();
        set_lookahead(16'hffff);
        random_phase(80);
        settle();
        set_lookahead(16'($urandom_range(1, 65534)));
        random_phase(100);
        settle();
        set_lookahead(16'($urandom_range(200, 3000)));
        random_phase(100);
        settle();
        set_lookahead(LOOKAHEAD_RST);
        random_phase(100);
        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_goals.size() == 0)
            $display("pursuit_lookahead_goal_search_tb: PASS");
        else
            $display("pursuit_lookahead_goal_search_tb: FAIL");
        $finish;
    end

endmodule
